FILE: sv/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the smoothstep fade sequencer
// Item structs, phase and register codes, controller commands and reset values.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Transition phases, also the encoding of the phase_now result field.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_IN   = 2'd1,
    PH_HOLD = 2'd2,
    PH_OUT  = 2'd3
  } phase_e;

  // Input operation codes.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // Configuration register indexes; index three is unused.
  typedef enum logic [1:0] {
    REG_FADE_IN  = 2'd0,
    REG_HOLD     = 2'd1,
    REG_FADE_OUT = 2'd2
  } reg_idx_e;

  // Controller states: one per datapath step.
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_ACC  = 3'd2,
    S_SQ   = 3'd3,
    S_CUBE = 3'd4,
    S_DONE = 3'd5
  } ctrl_state_e;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned T16_W      = 16;

  localparam logic [RATE_W-1:0] FADE_IN_RATE_RST  = 32'd14317;
  localparam logic [RATE_W-1:0] HOLD_RATE_RST     = 32'd42950;
  localparam logic [RATE_W-1:0] FADE_OUT_RATE_RST = 32'd14317;

  // 3 * 2^16, the constant term of the smoothstep polynomial.
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;
  // One in units of 2^-48.
  localparam logic [48:0] SMOOTH_ONE   = 49'h1_0000_0000_0000;
  localparam logic [7:0]  ALPHA_FULL   = 8'd255;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;

  typedef struct packed {
    logic        operation;
    logic [15:0] dt_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0] phase_now;
    logic [7:0] alpha;
    logic       switch_now;
    logic       finished;
  } out_item_t;

  typedef struct packed {
    logic              en;
    reg_idx_e          idx;
    logic [RATE_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_acc;
    logic do_sq;
    logic do_cube;
    logic load_out;
  } dp_cmd_t;

endpackage

FILE: sv/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl: sequencing state machine of the fade sequencer
// Steps the datapath through its five steps and owns both handshakes.
// ----------------------------------------------------------------------------
module sfs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sfs_pkg::dp_cmd_t cmd_o
);
  import sfs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  dp_cmd_t     cmd;
  logic        accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        cmd.do_acc = 1'b1;
        state_d    = S_SQ;
      end
      S_SQ: begin
        cmd.do_sq = 1'b1;
        state_d   = S_CUBE;
      end
      S_CUBE: begin
        cmd.do_cube = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // The result register may be refilled once it is empty or draining now.
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL))
    else $error("accepted item did not start the multiply step");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("result left the done step while the output was blocked");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_q)
    else $error("loaded result is not presented");

endmodule

FILE: sv/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath: rate registers, progress accumulator and smoothstep alpha
// Each step runs on a command from the controller and registers its result.
// ----------------------------------------------------------------------------
module sfs_datapath #(
  parameter int unsigned PROGRESS_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfs_pkg::dp_cmd_t               cmd_i,
  input  sfs_pkg::in_item_t              in_data_i,
  input  sfs_pkg::cfg_wr_t               cfg_wr_i,
  input  sfs_pkg::reg_idx_e              cfg_rd_idx_i,
  output logic [sfs_pkg::RATE_W-1:0]     cfg_rdata_o,
  output sfs_pkg::out_item_t             out_data_o
);
  import sfs_pkg::*;

  localparam int unsigned FRAC_SHIFT = 32 - PROGRESS_BITS;
  localparam int unsigned TW         = PROGRESS_BITS + T16_W;

  logic [RATE_W-1:0] fade_in_rate_q, hold_rate_q, fade_out_rate_q;
  phase_e            phase_q, phase_d;
  logic [PROGRESS_BITS-1:0] progress_q, progress_d;

  op_e         op_q;
  logic [DT_W-1:0] dt_q;
  logic [47:0] prod_q;
  logic        sw_q, sw_d, fin_q, fin_d;
  logic [31:0] sq_q;
  logic [48:0] s_q;
  out_item_t   out_q;

  logic [RATE_W-1:0] rate;
  logic [48:0] sum;
  logic        phase_end;
  logic [TW-1:0] t_wide;
  logic [T16_W-1:0] t16;
  logic [17:0] poly;
  logic [49:0] cube;
  logic [48:0] frac;
  logic [56:0] scaled;
  logic [7:0]  alpha;

  // Rate registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_in_rate_q  <= FADE_IN_RATE_RST;
      hold_rate_q     <= HOLD_RATE_RST;
      fade_out_rate_q <= FADE_OUT_RATE_RST;
    end else if (cfg_wr_i.en) begin
      unique case (cfg_wr_i.idx)
        REG_FADE_IN:  fade_in_rate_q  <= cfg_wr_i.data;
        REG_HOLD:     hold_rate_q     <= cfg_wr_i.data;
        REG_FADE_OUT: fade_out_rate_q <= cfg_wr_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_rd_idx_i)
      REG_FADE_IN:  cfg_rdata_o = fade_in_rate_q;
      REG_HOLD:     cfg_rdata_o = hold_rate_q;
      REG_FADE_OUT: cfg_rdata_o = fade_out_rate_q;
      default:      cfg_rdata_o = '0;
    endcase
  end

  always_comb begin
    unique case (phase_q)
      PH_IN:   rate = fade_in_rate_q;
      PH_HOLD: rate = hold_rate_q;
      default: rate = fade_out_rate_q;
    endcase
  end

  // Progress plus the scaled time, in units of 2^-32 of a phase.
  assign sum = {17'b0, progress_q, {FRAC_SHIFT{1'b0}}} + {1'b0, prod_q};
  assign phase_end = |sum[48:32];

  always_comb begin
    phase_d    = phase_q;
    progress_d = progress_q;
    sw_d       = 1'b0;
    fin_d      = 1'b0;
    if (op_q == OP_START) begin
      phase_d    = PH_IN;
      progress_d = '0;
    end else if (phase_q != PH_IDLE) begin
      if (phase_end) begin
        progress_d = '0;
        unique case (phase_q)
          PH_IN: begin
            phase_d = PH_HOLD;
            sw_d    = 1'b1;
          end
          PH_HOLD: phase_d = PH_OUT;
          default: begin
            phase_d = PH_IDLE;
            fin_d   = 1'b1;
          end
        endcase
      end else begin
        progress_d = sum[31:FRAC_SHIFT];
      end
    end
  end

  // Progress rescaled to a Q0.16 fraction, truncating.
  assign t_wide = {progress_q, {T16_W{1'b0}}} >> PROGRESS_BITS;
  assign t16    = t_wide[T16_W-1:0];
  assign poly   = SMOOTH_THREE - {1'b0, t16, 1'b0};
  assign cube   = {18'b0, sq_q} * {32'b0, poly};

  // 255 * x as a shift and a subtract; the fade-out uses one minus smoothstep.
  assign frac   = (phase_q == PH_OUT) ? (SMOOTH_ONE - s_q) : s_q;
  assign scaled = {frac, 8'b0} - {8'b0, frac};

  always_comb begin
    unique case (phase_q) inside
      PH_IN, PH_OUT: alpha = scaled[55:48];
      PH_HOLD:       alpha = ALPHA_FULL;
      default:       alpha = ALPHA_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      progress_q <= '0;
    end else if (cmd_i.do_acc) begin
      phase_q    <= phase_d;
      progress_q <= progress_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= op_e'(in_data_i.operation);
      dt_q <= in_data_i.dt_us;
    end
    if (cmd_i.do_mul) begin
      prod_q <= {32'b0, dt_q} * {16'b0, rate};
    end
    if (cmd_i.do_acc) begin
      sw_q  <= sw_d;
      fin_q <= fin_d;
    end
    if (cmd_i.do_sq) begin
      sq_q <= {16'b0, t16} * {16'b0, t16};
    end
    if (cmd_i.do_cube) begin
      s_q <= cube[48:0];
    end
    if (cmd_i.load_out) begin
      out_q.phase_now  <= phase_q;
      out_q.alpha      <= alpha;
      out_q.switch_now <= sw_q;
      out_q.finished   <= fin_q;
    end
  end

  assign out_data_o = out_q;

  a_idle_no_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (progress_q == '0))
    else $error("progress is nonzero while idle");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_acc |=> !(sw_q && fin_q))
    else $error("switch and finish pulses raised for the same item");

endmodule

FILE: sv/smoothstep_fade_sequencer.sv
// ----------------------------------------------------------------------------
// smoothstep_fade_sequencer: fade-to-black transition with smoothstep alpha
// Start and tick items drive a four-phase fade; each item yields one result.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   in_data_i  (operation, dt_us)
//   output   out        out_valid_o / out_stall_i out_data_o (phase, alpha, pulses)
//   config   in         APB psel/penable/pready   three 32-bit rate registers
//
// After its transfer an item passes through the rate multiply, the progress add
// and compare, the square, the smoothstep cube and the alpha scaling into the
// result register; in_stall_o holds off further input transfers meanwhile.
// A result waiting under out_stall_i holds the controller in its last step, so
// further input transfers wait until the result register can be refilled.
// Reset clears the phase to idle, progress to zero and the rates to defaults.
//
module smoothstep_fade_sequencer #(
  parameter int unsigned PROGRESS_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sfs_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sfs_pkg::out_item_t                out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import sfs_pkg::*;

  dp_cmd_t  cmd;
  cfg_wr_t  cfg_wr;
  reg_idx_e reg_idx;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign reg_idx    = reg_idx_e'(paddr[3:2]);
  assign pready     = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = reg_idx;
  assign cfg_wr.data = pwdata;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sfs_datapath #(
    .PROGRESS_BITS (PROGRESS_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_data_i    (in_data_i),
    .cfg_wr_i     (cfg_wr),
    .cfg_rd_idx_i (reg_idx),
    .cfg_rdata_o  (prdata),
    .out_data_o   (out_data_o)
  );

endmodule
